// File: sv/phi_coefficient_2x2_unit_macros.svh
// Assertion macros for the phi coefficient unit.
`ifndef PHI_COEFFICIENT_2X2_UNIT_MACROS_SVH
`define PHI_COEFFICIENT_2X2_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define PCU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define PCU_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/pcu_pkg.sv
// Package: widths, constants and shared types of the phi coefficient unit.
`timescale 1ns / 1ps
package pcu_pkg;

   localparam int COUNT_BITS = 16;
   localparam int MW         = COUNT_BITS + 1;
   localparam int TW         = COUNT_BITS + 2;
   localparam int DW         = 2 * COUNT_BITS;
   localparam int XW         = 2 * MW;
   localparam int PW         = 4 * MW;
   localparam int D2W        = 2 * DW;
   localparam int DTW        = DW + TW;
   localparam int RPW        = 2 * DW + 32;
   localparam int RSW        = 2 * DW + TW + 18;
   localparam int PHI_BITS   = 17;
   localparam int SCORE_BITS = ((COUNT_BITS + 3) / 2 + 9 > 19) ? (COUNT_BITS + 3) / 2 + 9 : 19;
   localparam int NSTEP      = SCORE_BITS;
   localparam int IW         = $clog2(NSTEP);
   localparam int SW         = 2 * SCORE_BITS + PW + 4;

   localparam logic [PHI_BITS-1:0]   PHI_POS_MAX   = PHI_BITS'(32767);
   localparam logic [PHI_BITS-1:0]   PHI_NEG_MAX   = PHI_BITS'(32768);
   localparam logic [SCORE_BITS-1:0] SCORE_POS_MAX = SCORE_BITS'(131071);
   localparam logic [SCORE_BITS-1:0] SCORE_NEG_MAX = SCORE_BITS'(131072);

   typedef struct packed {
      logic [15:0] group_id;
      logic [15:0] item_id;
      logic [15:0] count_pp;
      logic [15:0] count_pm;
      logic [15:0] count_mp;
      logic [15:0] count_mm;
   } in_type;

   typedef struct packed {
      logic [15:0] group_id;
      logic [15:0] item_id;
      logic        ok;
      logic        neg;
   } tag_type;

   typedef struct packed {
      logic                   vld;
      tag_type                tag;
      logic [PW-1:0]          p;
      logic signed [SW-1:0]   lp;
      logic signed [SW-1:0]   gp;
      logic signed [SW-1:0]   ls;
      logic signed [SW-1:0]   gs;
      logic [PHI_BITS-1:0]    mp;
      logic [SCORE_BITS-1:0]  ms;
   } search_type;

endpackage

// File: sv/pcu_if.sv
// Channel interfaces: request and response with valid/ready handshake.
`timescale 1ns / 1ps
interface pcu_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] group_id;
   logic [15:0] item_id;
   logic [15:0] count_pp;
   logic [15:0] count_pm;
   logic [15:0] count_mp;
   logic [15:0] count_mm;
   modport source (output valid, group_id, item_id, count_pp, count_pm, count_mp, count_mm,
                   input ready);
   modport sink (input valid, group_id, item_id, count_pp, count_pm, count_mp, count_mm,
                 output ready);
endinterface

interface pcu_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        group_tag;
   logic [15:0]        item_tag;
   logic signed [15:0] phi_value;
   logic signed [17:0] score_value;
   logic               valid_res;
   modport source (output valid, group_tag, item_tag, phi_value, score_value, valid_res,
                   input ready);
   modport sink (input valid, group_tag, item_tag, phi_value, score_value, valid_res,
                 output ready);
endinterface

// File: sv/phi_coefficient_2x2_unit.sv
// Top level: phi coefficient and score of a 2x2 contingency table.
// Path: front pipeline, root-search chain, then the response register.
// Throughput: one beat per cycle while the response is not stalled; the search chain retires one root bit per stage.
// A stalled response beat freezes every stage; nothing is dropped or repeated.
// Reset clears all stage valid bits and the response valid; payload registers keep data.
`timescale 1ns / 1ps
`include "phi_coefficient_2x2_unit_macros.svh"
module phi_coefficient_2x2_unit (
   input  logic      clock,
   input  logic      reset,
   pcu_req_if.sink   req_ch,
   pcu_rsp_if.source rsp_ch
);
   import pcu_pkg::*;

   logic       adv;
   in_type     in_data;
   search_type chain [NSTEP+1];

   always_comb begin
      in_data.group_id = req_ch.group_id;
      in_data.item_id  = req_ch.item_id;
      in_data.count_pp = req_ch.count_pp;
      in_data.count_pm = req_ch.count_pm;
      in_data.count_mp = req_ch.count_mp;
      in_data.count_mm = req_ch.count_mm;
   end

   assign req_ch.ready = adv;

   pcu_front u_front (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (req_ch.valid),
      .in_data (in_data),
      .out_st  (chain[0])
   );

   for (genvar s = 0; s < NSTEP; s++) begin : g_root
      pcu_root_stage u_stage (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .bit_idx (IW'(NSTEP - 1 - s)),
         .in_st   (chain[s]),
         .out_st  (chain[s+1])
      );
   end

   pcu_back u_back (
      .clock  (clock),
      .reset  (reset),
      .in_st  (chain[NSTEP]),
      .adv    (adv),
      .rsp_ch (rsp_ch)
   );

   `PCU_ASSERT_IMP(a_invalid_zero, rsp_ch.valid && !rsp_ch.valid_res, rsp_ch.phi_value == 16'sd0 && rsp_ch.score_value == 18'sd0, "invalid table with nonzero result")
   `PCU_ASSERT_IMP(a_sign_pos, rsp_ch.valid && rsp_ch.phi_value > 16'sd0, rsp_ch.score_value >= 18'sd0, "score sign disagrees with positive phi")
   `PCU_ASSERT_IMP(a_sign_neg, rsp_ch.valid && rsp_ch.phi_value < 16'sd0, rsp_ch.score_value <= 18'sd0, "score sign disagrees with negative phi")
   `PCU_ASSERT_NXT(a_drain, rsp_ch.valid && rsp_ch.ready && !chain[NSTEP].vld, !rsp_ch.valid, "response beat repeated")
endmodule

// File: sv/pcu_front.sv
// Front pipeline: marginals, products, determinant and both right-hand sides.
`timescale 1ns / 1ps
module pcu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_vld,
   input  pcu_pkg::in_type     in_data,
   output pcu_pkg::search_type out_st
);
   import pcu_pkg::*;

   typedef struct packed {
      logic vld; tag_type tag;
      logic [MW-1:0] rp; logic [MW-1:0] rm; logic [MW-1:0] cp; logic [MW-1:0] cm;
      logic [TW-1:0] total; logic [DW-1:0] a; logic [DW-1:0] b;
   } s1_type;
   typedef struct packed {
      logic vld; tag_type tag;
      logic [XW-1:0] x; logic [XW-1:0] y; logic [TW-1:0] total; logic [DW-1:0] d;
   } s2_type;
   typedef struct packed {
      logic vld; tag_type tag;
      logic [PW-1:0] p; logic [D2W-1:0] d2; logic [DTW-1:0] dt; logic [DW-1:0] d;
   } s3_type;
   typedef struct packed {
      logic vld; tag_type tag;
      logic [PW-1:0] p; logic [RPW-1:0] rphi;
      logic [DTW+COUNT_BITS-1:0] lo; logic [DTW+COUNT_BITS-1:0] hi;
   } s4_type;
   typedef struct packed {
      logic vld; tag_type tag;
      logic [PW-1:0] p; logic [RPW-1:0] rphi; logic [RSW-1:0] rs;
   } s5_type;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;
   search_type s6_in, s6_ff;

   logic [COUNT_BITS-1:0] pp, pm, mp, mm;

   always_comb begin
      pp = COUNT_BITS'(in_data.count_pp);
      pm = COUNT_BITS'(in_data.count_pm);
      mp = COUNT_BITS'(in_data.count_mp);
      mm = COUNT_BITS'(in_data.count_mm);
      s1_in.vld          = in_vld;
      s1_in.tag.group_id = in_data.group_id;
      s1_in.tag.item_id  = in_data.item_id;
      s1_in.rp           = MW'(pp) + MW'(pm);
      s1_in.rm           = MW'(mp) + MW'(mm);
      s1_in.cp           = MW'(pp) + MW'(mp);
      s1_in.cm           = MW'(pm) + MW'(mm);
      s1_in.tag.ok       = (s1_in.rp != '0) && (s1_in.rm != '0) &&
                           (s1_in.cp != '0) && (s1_in.cm != '0);
      s1_in.tag.neg      = 1'b0;
      s1_in.total        = TW'(pp) + TW'(pm) + TW'(mp) + TW'(mm);
      s1_in.a            = DW'(pp) * DW'(mm);
      s1_in.b            = DW'(pm) * DW'(mp);
   end

   always_comb begin
      s2_in.vld     = s1_ff.vld;
      s2_in.tag     = s1_ff.tag;
      s2_in.tag.neg = s1_ff.a < s1_ff.b;
      s2_in.d       = s2_in.tag.neg ? s1_ff.b - s1_ff.a : s1_ff.a - s1_ff.b;
      s2_in.x       = XW'(s1_ff.rp) * XW'(s1_ff.rm);
      s2_in.y       = XW'(s1_ff.cp) * XW'(s1_ff.cm);
      s2_in.total   = s1_ff.total;
   end

   always_comb begin
      s3_in.vld = s2_ff.vld;
      s3_in.tag = s2_ff.tag;
      s3_in.p   = PW'(s2_ff.x) * PW'(s2_ff.y);
      s3_in.d2  = D2W'(s2_ff.d) * D2W'(s2_ff.d);
      s3_in.dt  = DTW'(s2_ff.d) * DTW'(s2_ff.total);
      s3_in.d   = s2_ff.d;
   end

   always_comb begin
      s4_in.vld  = s3_ff.vld;
      s4_in.tag  = s3_ff.tag;
      s4_in.p    = s3_ff.p;
      s4_in.rphi = RPW'(s3_ff.d2) << 32;
      s4_in.lo   = (DTW+COUNT_BITS)'(s3_ff.dt) * (DTW+COUNT_BITS)'(s3_ff.d[COUNT_BITS-1:0]);
      s4_in.hi   = (DTW+COUNT_BITS)'(s3_ff.dt) * (DTW+COUNT_BITS)'(s3_ff.d[DW-1:COUNT_BITS]);
   end

   always_comb begin
      s5_in.vld  = s4_ff.vld;
      s5_in.tag  = s4_ff.tag;
      s5_in.p    = s4_ff.p;
      s5_in.rphi = s4_ff.rphi;
      s5_in.rs   = RSW'((DTW+DW)'(s4_ff.lo) + ((DTW+DW)'(s4_ff.hi) << COUNT_BITS)) << 18;
   end

   always_comb begin
      s6_in.vld = s5_ff.vld;
      s6_in.tag = s5_ff.tag;
      s6_in.p   = s5_ff.p;
      s6_in.lp  = SW'(0) - SW'(s5_ff.p);
      s6_in.ls  = SW'(0) - SW'(s5_ff.p);
      s6_in.gp  = SW'(s5_ff.rphi) - SW'(s5_ff.p);
      s6_in.gs  = SW'(s5_ff.rs) - SW'(s5_ff.p);
      s6_in.mp  = '0;
      s6_in.ms  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld <= 1'b0;
         s2_ff.vld <= 1'b0;
         s3_ff.vld <= 1'b0;
         s4_ff.vld <= 1'b0;
         s5_ff.vld <= 1'b0;
         s6_ff.vld <= 1'b0;
      end else if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   assign out_st = s6_ff;
endmodule

// File: sv/pcu_root_stage.sv
// One bit of the rounded square-root quotient search for phi and score.
`timescale 1ns / 1ps
module pcu_root_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic [pcu_pkg::IW-1:0] bit_idx,
   input  pcu_pkg::search_type in_st,
   output pcu_pkg::search_type out_st
);
   import pcu_pkg::*;

   search_type st_in, st_ff;
   logic [IW+1:0] sh_l, sh_p, sh_n;
   logic signed [SW-1:0] pext, gp_try, gs_try;
   logic phi_pass, score_pass;

   always_comb begin
      sh_n     = (IW+2)'(bit_idx) + (IW+2)'(1);
      sh_l     = (IW+2)'(bit_idx) + (IW+2)'(2);
      sh_p     = ((IW+2)'(bit_idx) << 1) + (IW+2)'(2);
      pext     = SW'(in_st.p);
      gp_try   = in_st.gp - ((in_st.lp <<< sh_l) + (pext << sh_p));
      gs_try   = in_st.gs - ((in_st.ls <<< sh_l) + (pext << sh_p));
      phi_pass   = (int'(bit_idx) < PHI_BITS) && !gp_try[SW-1];
      score_pass = !gs_try[SW-1];
      st_in = in_st;
      if (phi_pass) begin
         st_in.gp = gp_try;
         st_in.lp = in_st.lp + (pext << sh_n);
         st_in.mp = in_st.mp | (PHI_BITS'(1) << bit_idx);
      end
      if (score_pass) begin
         st_in.gs = gs_try;
         st_in.ls = in_st.ls + (pext << sh_n);
         st_in.ms = in_st.ms | (SCORE_BITS'(1) << bit_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.vld <= 1'b0;
      end else if (adv) begin
         st_ff <= st_in;
      end
   end

   assign out_st = st_ff;
endmodule

// File: sv/pcu_back.sv
// Output stage: clamp, sign and the response register.
`timescale 1ns / 1ps
module pcu_back (
   input  logic                clock,
   input  logic                reset,
   input  pcu_pkg::search_type in_st,
   output logic                adv,
   pcu_rsp_if.source           rsp_ch
);
   import pcu_pkg::*;

   logic                  out_vld_ff;
   logic [15:0]           group_ff, item_ff;
   logic signed [15:0]    phi_ff, phi_in;
   logic signed [17:0]    score_ff, score_in;
   logic                  res_ff;
   logic [PHI_BITS-1:0]   pcap, pmag;
   logic [SCORE_BITS-1:0] scap, smag;

   always_comb begin
      adv   = !out_vld_ff || rsp_ch.ready;
      pcap  = in_st.tag.neg ? PHI_NEG_MAX : PHI_POS_MAX;
      scap  = in_st.tag.neg ? SCORE_NEG_MAX : SCORE_POS_MAX;
      pmag  = (in_st.mp > pcap) ? pcap : in_st.mp;
      smag  = (in_st.ms > scap) ? scap : in_st.ms;
      phi_in   = '0;
      score_in = '0;
      if (in_st.tag.ok) begin
         phi_in   = in_st.tag.neg ? 16'(0) - 16'(pmag) : 16'(pmag);
         score_in = in_st.tag.neg ? 18'(0) - 18'(smag) : 18'(smag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= in_st.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         group_ff <= in_st.tag.group_id;
         item_ff  <= in_st.tag.item_id;
         phi_ff   <= phi_in;
         score_ff <= score_in;
         res_ff   <= in_st.tag.ok;
      end
   end

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.group_tag   = group_ff;
   assign rsp_ch.item_tag    = item_ff;
   assign rsp_ch.phi_value   = phi_ff;
   assign rsp_ch.score_value = score_ff;
   assign rsp_ch.valid_res   = res_ff;
endmodule
